### design/sparse_matrix_multiply_top_macros.svh
// ----------------------------------------------------------------------------
// Sparse matrix multiply assertion macros
// Assertion forms used by the sparse matrix multiply back end.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define SPARSE_MATRIX_MULTIPLY_TOP_MACROS_SVH

// Implication checked at every edge outside reset.
`define SMM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define SMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/smm_pkg.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply package
// Command and status codes and the classified request passed front to back.
// ----------------------------------------------------------------------------
package smm_pkg;

   localparam int MAX_DIM = 16;

   localparam int CMD_BITS = 2;
   localparam int IDX_BITS = 4;
   localparam int DIM_BITS = 5;
   localparam int IN_VALUE_BITS = 16;
   localparam int OUT_VALUE_BITS = 40;
   localparam int STATUS_BITS = 2;

   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_APPLY = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_DRAIN = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DIM      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_ROW_FULL = 2'd3;

   localparam logic [1:0] REG_A_ROWS = 2'd0;
   localparam logic [1:0] REG_A_COLS = 2'd1;
   localparam logic [1:0] REG_B_ROWS = 2'd2;
   localparam logic [1:0] REG_B_COLS = 2'd3;

   typedef enum logic [2:0] {
      OP_STATUS,
      OP_CLEAR,
      OP_LOAD,
      OP_APPLY,
      OP_DRAIN
   } op_type;

   typedef struct packed {
      op_type                           op;
      logic [STATUS_BITS-1:0]           status;
      logic [IDX_BITS-1:0]              row;
      logic [IDX_BITS-1:0]              col;
      logic signed [IN_VALUE_BITS-1:0]  value;
      logic [DIM_BITS-1:0]              count;
   } job_type;

endpackage

### design/smm_req_if.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply request channel
// Valid and ready handshake carrying one command request.
// ----------------------------------------------------------------------------
interface smm_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [smm_pkg::CMD_BITS-1:0]             cmd;
   logic [smm_pkg::IDX_BITS-1:0]             row_index;
   logic [smm_pkg::IDX_BITS-1:0]             col_index;
   logic signed [smm_pkg::IN_VALUE_BITS-1:0] entry_value;

   modport source (output valid, cmd, row_index, col_index, entry_value, input ready);
   modport sink (input valid, cmd, row_index, col_index, entry_value, output ready);
endinterface

### design/smm_rsp_if.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply result channel
// Valid and ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface smm_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [smm_pkg::STATUS_BITS-1:0]           status;
   logic [smm_pkg::IDX_BITS-1:0]              out_row;
   logic [smm_pkg::IDX_BITS-1:0]              out_col;
   logic signed [smm_pkg::OUT_VALUE_BITS-1:0] product_value;
   logic                                      last;

   modport source (output valid, status, out_row, out_col, product_value, last,
                   input ready);
   modport sink (input valid, status, out_row, out_col, product_value, last,
                 output ready);
endinterface

### design/smm_front.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply front end
// Checks dimensions and indexes, keeps the B row counts and emits jobs.
// ----------------------------------------------------------------------------
module smm_front (
   input  logic                            clock,
   input  logic                            reset,
   smm_req_if.sink                         req,
   input  logic [smm_pkg::DIM_BITS-1:0]    a_rows,
   input  logic [smm_pkg::DIM_BITS-1:0]    a_cols,
   input  logic [smm_pkg::DIM_BITS-1:0]    b_rows,
   input  logic [smm_pkg::DIM_BITS-1:0]    b_cols,
   output logic                            job_valid,
   input  logic                            job_ready,
   output smm_pkg::job_type                job
);

   localparam int MAX_DIM  = smm_pkg::MAX_DIM;
   localparam int CNT_BITS = $clog2(MAX_DIM + 1);

   logic [CNT_BITS-1:0] count_ff [MAX_DIM];
   logic                dims_ok;
   logic                take;
   logic [CNT_BITS-1:0] n;
   logic [smm_pkg::DIM_BITS-1:0] row_ext;
   logic [smm_pkg::DIM_BITS-1:0] col_ext;
   logic [smm_pkg::DIM_BITS-1:0] max_dim;
   logic                row_ok;
   logic                col_ok;

   assign max_dim = smm_pkg::DIM_BITS'(MAX_DIM > 31 ? 31 : MAX_DIM);
   assign row_ext = {1'b0, req.row_index};
   assign col_ext = {1'b0, req.col_index};
   assign row_ok  = 32'(req.row_index) < MAX_DIM;
   assign col_ok  = 32'(req.col_index) < MAX_DIM;
   assign dims_ok = a_rows != '0 && a_cols != '0 && b_rows != '0 && b_cols != '0 &&
                    32'(a_rows) <= MAX_DIM && 32'(a_cols) <= MAX_DIM &&
                    32'(b_rows) <= MAX_DIM && 32'(b_cols) <= MAX_DIM &&
                    a_cols == b_rows && max_dim != '0;

   assign req.ready = job_ready;
   assign job_valid = req.valid;
   assign take      = req.valid && job_ready;
   assign n = col_ok ? count_ff[req.col_index[$clog2(MAX_DIM)-1:0]] : '0;

   always_comb begin
      job.row    = req.row_index;
      job.col    = '0;
      job.value  = req.entry_value;
      job.count  = '0;
      job.status = smm_pkg::ST_OK;
      job.op     = smm_pkg::OP_STATUS;
      if (req.cmd == smm_pkg::CMD_CLEAR) begin
         job.row = '0;
         job.op  = smm_pkg::OP_CLEAR;
      end else if (!dims_ok) begin
         job.status = smm_pkg::ST_DIM;
      end else begin
         case (req.cmd)
            smm_pkg::CMD_LOAD: begin
               job.col = req.col_index;
               if (row_ext >= b_rows || col_ext >= b_cols) begin
                  job.status = smm_pkg::ST_RANGE;
               end else if (32'(count_ff[req.row_index[$clog2(MAX_DIM)-1:0]]) >= MAX_DIM)
               begin
                  job.status = smm_pkg::ST_ROW_FULL;
               end else begin
                  job.op    = smm_pkg::OP_LOAD;
                  job.count = smm_pkg::DIM_BITS'(count_ff[req.row_index[$clog2(MAX_DIM)-1:0]]);
               end
            end
            smm_pkg::CMD_APPLY: begin
               job.col = req.col_index;
               if (row_ext >= a_rows || col_ext >= a_cols) begin
                  job.status = smm_pkg::ST_RANGE;
               end else begin
                  job.op    = smm_pkg::OP_APPLY;
                  job.count = smm_pkg::DIM_BITS'(n);
               end
            end
            smm_pkg::CMD_DRAIN: begin
               if (row_ext >= a_rows) begin
                  job.status = smm_pkg::ST_RANGE;
               end else begin
                  job.op    = smm_pkg::OP_DRAIN;
                  job.count = b_cols;
               end
            end
            default: begin
               job.op = smm_pkg::OP_CLEAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIM; i++) begin
            count_ff[i] <= '0;
         end
      end else if (take) begin
         if (job.op == smm_pkg::OP_CLEAR) begin
            for (int i = 0; i < MAX_DIM; i++) begin
               count_ff[i] <= '0;
            end
         end else if (job.op == smm_pkg::OP_LOAD && row_ok) begin
            count_ff[req.row_index[$clog2(MAX_DIM)-1:0]] <= CNT_BITS'(job.count) + 1'b1;
         end
      end
   end

endmodule

### design/smm_queue.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module smm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  smm_pkg::job_type  in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output smm_pkg::job_type  out_job
);

   smm_pkg::job_type slot_ff [2];
   logic             wr_ff;
   logic             rd_ff;
   logic [1:0]       fill_ff;
   logic             push;
   logic             pop;

   assign in_ready  = fill_ff != 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign out_job   = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_job;
      end
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### design/smm_back.sv
// ----------------------------------------------------------------------------
// Sparse matrix multiply back end
// Stores B entries, accumulates products and drains product rows.
// ----------------------------------------------------------------------------
`include "sparse_matrix_multiply_top_macros.svh"

module smm_back #(
   parameter int VALUE_BITS = 16,
   parameter int ACC_BITS   = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  smm_pkg::job_type  job,
   smm_rsp_if.source         rsp
);

   localparam int MAX_DIM = smm_pkg::MAX_DIM;
   localparam int IW    = $clog2(MAX_DIM);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = 2 * IW;
   localparam int PW    = 2 * VALUE_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_READ, S_MUL, S_ACC_RD, S_ACC_WR,
      S_DRAIN_RD, S_DRAIN_OUT, S_SEND
   } state_type;

   state_type state_ff;
   smm_pkg::job_type job_ff;
   logic [IW:0]   step_ff;
   logic [AW-1:0] sweep_ff;
   logic [IW-1:0] bcol_store [DEPTH];
   logic signed [VALUE_BITS-1:0] bval_store [DEPTH];
   logic [ACC_BITS-1:0] acc_mem [DEPTH];
   logic [IW-1:0] bcol_ff;
   logic signed [VALUE_BITS-1:0] bval_ff;
   logic signed [PW-1:0] prod_ff;
   logic [ACC_BITS-1:0] acc_rd_ff;
   logic acc_we;
   logic [AW-1:0] acc_waddr;
   logic [ACC_BITS-1:0] acc_wdata;
   logic [AW-1:0] acc_raddr;
   logic signed [VALUE_BITS-1:0] a_val;
   logic [AW-1:0] b_addr;

   logic rsp_valid_ff;
   logic [smm_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [smm_pkg::IDX_BITS-1:0] rsp_row_ff;
   logic [smm_pkg::IDX_BITS-1:0] rsp_col_ff;
   logic signed [smm_pkg::OUT_VALUE_BITS-1:0] rsp_value_ff;
   logic rsp_last_ff;
   logic rsp_free;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.out_row       = rsp_row_ff;
   assign rsp.out_col       = rsp_col_ff;
   assign rsp.product_value = rsp_value_ff;
   assign rsp.last          = rsp_last_ff;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign job_ready = state_ff == S_IDLE;
   assign a_val     = VALUE_BITS'(job_ff.value);
   assign b_addr    = {job_ff.col[IW-1:0], step_ff[IW-1:0]};

   always_comb begin
      acc_we    = 1'b0;
      acc_waddr = {job_ff.row[IW-1:0], bcol_ff};
      acc_wdata = acc_rd_ff + ACC_BITS'(prod_ff);
      acc_raddr = {job_ff.row[IW-1:0], bcol_ff};
      if (state_ff == S_CLEAR) begin
         acc_we    = 1'b1;
         acc_waddr = sweep_ff;
         acc_wdata = '0;
      end else if (state_ff == S_ACC_WR) begin
         acc_we = 1'b1;
      end
      if (state_ff == S_DRAIN_RD || state_ff == S_DRAIN_OUT) begin
         acc_raddr = {job_ff.row[IW-1:0], step_ff[IW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
      if (state_ff == S_IDLE && job_valid && job.op == smm_pkg::OP_LOAD) begin
         bcol_store[{job.row[IW-1:0], job.count[IW-1:0]}] <= job.col[IW-1:0];
         bval_store[{job.row[IW-1:0], job.count[IW-1:0]}] <= VALUE_BITS'(job.value);
      end
      bcol_ff <= bcol_store[b_addr];
      bval_ff <= bval_store[b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         job_ff       <= '0;
         sweep_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff  <= job;
                  step_ff <= '0;
                  sweep_ff <= '0;
                  case (job.op)
                     smm_pkg::OP_CLEAR:   state_ff <= S_CLEAR;
                     smm_pkg::OP_APPLY:   state_ff <= (job.count == '0) ? S_SEND : S_READ;
                     smm_pkg::OP_DRAIN:   state_ff <= S_DRAIN_RD;
                     default:             state_ff <= S_SEND;
                  endcase
               end
            end
            S_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == AW'(DEPTH - 1)) begin
                  state_ff <= (job_ff.op == smm_pkg::OP_CLEAR) ? S_SEND : S_IDLE;
               end
            end
            S_READ: state_ff <= S_MUL;
            S_MUL: begin
               prod_ff  <= PW'(a_val * bval_ff);
               state_ff <= S_ACC_RD;
            end
            S_ACC_RD: state_ff <= S_ACC_WR;
            S_ACC_WR: begin
               if (32'(step_ff) + 1 >= 32'(job_ff.count)) begin
                  state_ff <= S_SEND;
               end else begin
                  step_ff  <= step_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_DRAIN_RD: state_ff <= S_DRAIN_OUT;
            S_DRAIN_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= smm_pkg::ST_OK;
                  rsp_row_ff    <= job_ff.row;
                  rsp_col_ff    <= smm_pkg::IDX_BITS'(step_ff);
                  rsp_value_ff  <= smm_pkg::OUT_VALUE_BITS'(signed'(acc_rd_ff));
                  rsp_last_ff   <= 32'(step_ff) + 1 == 32'(job_ff.count);
                  if (32'(step_ff) + 1 == 32'(job_ff.count)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     step_ff  <= step_ff + 1'b1;
                     state_ff <= S_DRAIN_RD;
                  end
               end
            end
            S_SEND: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= job_ff.status;
                  rsp_row_ff    <= job_ff.row;
                  rsp_col_ff    <= '0;
                  rsp_value_ff  <= '0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `SMM_ASSERT_IMP(a_busy_no_take, clock, reset, state_ff != S_IDLE, !job_ready)
   `SMM_ASSERT_NEXT(a_send_valid, clock, reset, state_ff == S_SEND && rsp_free, rsp_valid_ff)
   `SMM_ASSERT_IMP(a_drain_ok, clock, reset, state_ff == S_DRAIN_OUT,
                   job_ff.op == smm_pkg::OP_DRAIN)

endmodule

### design/sparse_matrix_multiply_top.sv
// One request is handled at a time in the back end: clear sweeps the accumulator memory
// (a sweep that is also run once after reset before any request is taken), apply steps
// through each stored entry of the selected B row in turn (read, multiply, accumulator
// read, accumulator write), and drain reads and sends the product columns one at a time;
// the back end takes no new request until it is through with the one before.
// ----------------------------------------------------------------------------
// Sparse matrix multiply top level
// Row-wise sparse product with a classifying front end and a queued back end.
// ----------------------------------------------------------------------------
module sparse_matrix_multiply_top #(
   parameter int VALUE_BITS = 16,
   parameter int ACC_BITS   = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   smm_req_if.sink                      req,
   smm_rsp_if.source                    rsp,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [smm_pkg::DIM_BITS-1:0] csr_write_data
);

   logic [smm_pkg::DIM_BITS-1:0] a_rows_ff;
   logic [smm_pkg::DIM_BITS-1:0] a_cols_ff;
   logic [smm_pkg::DIM_BITS-1:0] b_rows_ff;
   logic [smm_pkg::DIM_BITS-1:0] b_cols_ff;
   logic             f_valid;
   logic             f_ready;
   smm_pkg::job_type f_job;
   logic             q_valid;
   logic             q_ready;
   smm_pkg::job_type q_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= 5'd16;
         a_cols_ff <= 5'd16;
         b_rows_ff <= 5'd16;
         b_cols_ff <= 5'd16;
      end else if (csr_write_enable) begin
         case (csr_index)
            smm_pkg::REG_A_ROWS: a_rows_ff <= csr_write_data;
            smm_pkg::REG_A_COLS: a_cols_ff <= csr_write_data;
            smm_pkg::REG_B_ROWS: b_rows_ff <= csr_write_data;
            smm_pkg::REG_B_COLS: b_cols_ff <= csr_write_data;
            default: a_rows_ff <= a_rows_ff;
         endcase
      end
   end

   smm_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .a_rows(a_rows_ff), .a_cols(a_cols_ff), .b_rows(b_rows_ff), .b_cols(b_cols_ff),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   smm_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   smm_back #(.VALUE_BITS(VALUE_BITS), .ACC_BITS(ACC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job), .rsp(rsp)
   );

endmodule

### dv/sparse_matrix_multiply_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse matrix multiply testbench
// Drives clear, load, apply and drain requests through the request channel
// under several register settings and random handshake idling. Every result
// is checked against the row-wise product model in this bench or a fixed expected result.
// ----------------------------------------------------------------------------
module sparse_matrix_multiply_top_tb;

   localparam int DIM = smm_pkg::MAX_DIM;

   typedef struct packed {
      logic [smm_pkg::STATUS_BITS-1:0]    status;
      logic [smm_pkg::IDX_BITS-1:0]       row;
      logic [smm_pkg::IDX_BITS-1:0]       col;
      logic [smm_pkg::OUT_VALUE_BITS-1:0] value;
      logic                               last;
   } result_type;

   typedef struct {
      int                                       phase;
      logic [smm_pkg::CMD_BITS-1:0]             cmd;
      logic [smm_pkg::IDX_BITS-1:0]             row;
      logic [smm_pkg::IDX_BITS-1:0]             col;
      logic signed [smm_pkg::IN_VALUE_BITS-1:0] value;
      bit                                       fixed;
      logic [smm_pkg::STATUS_BITS-1:0]          status;
   } stim_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [smm_pkg::DIM_BITS-1:0] csr_write_data;

   smm_req_if req ();
   smm_rsp_if rsp ();

   sparse_matrix_multiply_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req.sink),
      .rsp              (rsp.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [smm_pkg::DIM_BITS-1:0] dim_reg [4];
   logic [smm_pkg::DIM_BITS-1:0] row_count [DIM];
   logic [smm_pkg::IDX_BITS-1:0] col_store [DIM*DIM];
   logic signed [smm_pkg::IN_VALUE_BITS-1:0] value_store [DIM*DIM];
   logic [smm_pkg::OUT_VALUE_BITS-1:0] accumulator [DIM*DIM];

   result_type expected_results [$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_go = 0;
   logic hold_on = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit dims_legal();
      for (int i = 0; i < 4; i++) begin
         if (dim_reg[i] == 0 || dim_reg[i] > DIM) return 0;
      end
      return dim_reg[smm_pkg::REG_A_COLS] == dim_reg[smm_pkg::REG_B_ROWS];
   endfunction

   task automatic predict_product(input logic [smm_pkg::CMD_BITS-1:0] cmd,
                                  input logic [smm_pkg::IDX_BITS-1:0] row,
                                  input logic [smm_pkg::IDX_BITS-1:0] col,
                                  input logic signed [smm_pkg::IN_VALUE_BITS-1:0] value,
                                  ref result_type outs [$]);
      result_type r;
      logic signed [smm_pkg::OUT_VALUE_BITS-1:0] prod;
      int n;
      r = '{status: smm_pkg::ST_OK, row: row, col: '0, value: '0, last: 1'b1};
      if (cmd == smm_pkg::CMD_CLEAR) begin
         foreach (row_count[i]) row_count[i] = '0;
         foreach (accumulator[i]) accumulator[i] = '0;
         r.row = '0;
      end else if (!dims_legal()) begin
         r.status = smm_pkg::ST_DIM;
      end else if (cmd == smm_pkg::CMD_LOAD) begin
         if (row >= dim_reg[smm_pkg::REG_B_ROWS] || col >= dim_reg[smm_pkg::REG_B_COLS]) begin
            r.status = smm_pkg::ST_RANGE;
         end else if (row_count[row] >= DIM) begin
            r.status = smm_pkg::ST_ROW_FULL;
         end else begin
            col_store[row*DIM + row_count[row]] = col;
            value_store[row*DIM + row_count[row]] = value;
            row_count[row] = row_count[row] + smm_pkg::DIM_BITS'(1);
         end
      end else if (cmd == smm_pkg::CMD_APPLY) begin
         if (row >= dim_reg[smm_pkg::REG_A_ROWS] || col >= dim_reg[smm_pkg::REG_A_COLS]) begin
            r.status = smm_pkg::ST_RANGE;
         end else begin
            n = int'(row_count[col]);
            for (int s = 0; s < n; s++) begin
               prod = value * value_store[col*DIM + s];
               accumulator[row*DIM + col_store[col*DIM + s]] =
                  accumulator[row*DIM + col_store[col*DIM + s]] + prod;
            end
         end
      end else if (row >= dim_reg[smm_pkg::REG_A_ROWS]) begin
         r.status = smm_pkg::ST_RANGE;
      end else begin
         for (int j = 0; j < dim_reg[smm_pkg::REG_B_COLS]; j++) begin
            r.col = smm_pkg::IDX_BITS'(j);
            r.value = accumulator[row*DIM + j];
            r.last = (j + 1 == dim_reg[smm_pkg::REG_B_COLS]);
            outs.push_back(r);
         end
         return;
      end
      outs.push_back(r);
   endtask

   task automatic send_request(input logic [smm_pkg::CMD_BITS-1:0] cmd,
                               input logic [smm_pkg::IDX_BITS-1:0] row,
                               input logic [smm_pkg::IDX_BITS-1:0] col,
                               input logic signed [smm_pkg::IN_VALUE_BITS-1:0] value,
                               input bit fixed = 0,
                               input logic [smm_pkg::STATUS_BITS-1:0] status = smm_pkg::ST_OK);
      result_type outs [$];
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.row_index <= row;
      req.col_index <= col;
      req.entry_value <= value;
      do @(posedge clock); while (!req.ready);
      predict_product(cmd, row, col, value, outs);
      if (fixed)
         outs = '{'{status: status, row: (cmd == smm_pkg::CMD_CLEAR) ? '0 : row, col: '0,
                    value: '0, last: 1'b1}};
      foreach (outs[i]) expected_results.push_back(outs[i]);
   endtask

   task automatic set_dims(input logic [smm_pkg::DIM_BITS-1:0] ar,
                           input logic [smm_pkg::DIM_BITS-1:0] ac,
                           input logic [smm_pkg::DIM_BITS-1:0] br,
                           input logic [smm_pkg::DIM_BITS-1:0] bc);
      logic [smm_pkg::DIM_BITS-1:0] vals [4];
      vals = '{ar, ac, br, bc};
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= 2'(i);
         csr_write_data <= vals[i];
         @(posedge clock);
         dim_reg[i] = vals[i];
      end
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.status, rsp.out_row, rsp.out_col, rsp.product_value, rsp.last};
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result: actual %p", $realtime, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got != want) begin
               $display("%0t mismatch: expected %p, actual %p", $realtime, want, got);
               errors++;
            end
         end
      end
      rsp.ready <= !hold_on && ($urandom_range(99) >= recv_idle);
   end

   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (600) @(posedge clock);
      hold_on <= 1'b0;
   end

   stim_type directed [27] = '{
      '{0, smm_pkg::CMD_CLEAR, 4'd0,  4'd0,  16'sd0,  1, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_DRAIN, 4'd0,  4'd0,  16'sd0,  0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_LOAD,  4'd0,  4'd15, 16'sd32767, 1, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_LOAD,  4'd15, 4'd0,  -16'sd32768, 1, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_LOAD,  4'd0,  4'd0,  -16'sd1, 1, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_APPLY, 4'd15, 4'd0,  -16'sd32768, 0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_APPLY, 4'd0,  4'd15, 16'sd32767, 0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_APPLY, 4'd3,  4'd15, -16'sd1, 0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_DRAIN, 4'd15, 4'd9,  16'sd5,  0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_DRAIN, 4'd0,  4'd0,  16'sd0,  0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_LOAD,  4'd15, 4'd0,  -16'sd32768, 0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_APPLY, 4'd15, 4'd15, -16'sd32768, 0, smm_pkg::ST_OK},
      '{0, smm_pkg::CMD_DRAIN, 4'd15, 4'd0,  16'sd0,  0, smm_pkg::ST_OK},
      '{1, smm_pkg::CMD_LOAD,  4'd6,  4'd0,  16'sd1,  1, smm_pkg::ST_RANGE},
      '{1, smm_pkg::CMD_LOAD,  4'd2,  4'd5,  16'sd1,  1, smm_pkg::ST_RANGE},
      '{1, smm_pkg::CMD_APPLY, 4'd4,  4'd0,  16'sd1,  1, smm_pkg::ST_RANGE},
      '{1, smm_pkg::CMD_APPLY, 4'd0,  4'd6,  16'sd1,  1, smm_pkg::ST_RANGE},
      '{1, smm_pkg::CMD_DRAIN, 4'd4,  4'd0,  16'sd0,  1, smm_pkg::ST_RANGE},
      '{1, smm_pkg::CMD_LOAD,  4'd5,  4'd4,  16'sd100, 0, smm_pkg::ST_OK},
      '{1, smm_pkg::CMD_APPLY, 4'd3,  4'd5,  -16'sd7, 0, smm_pkg::ST_OK},
      '{1, smm_pkg::CMD_DRAIN, 4'd3,  4'd0,  16'sd0,  0, smm_pkg::ST_OK},
      '{2, smm_pkg::CMD_LOAD,  4'd0,  4'd0,  16'sd1,  1, smm_pkg::ST_DIM},
      '{2, smm_pkg::CMD_APPLY, 4'd1,  4'd0,  16'sd1,  1, smm_pkg::ST_DIM},
      '{2, smm_pkg::CMD_DRAIN, 4'd2,  4'd0,  16'sd0,  1, smm_pkg::ST_DIM},
      '{2, smm_pkg::CMD_CLEAR, 4'd7,  4'd3,  16'sd9,  1, smm_pkg::ST_OK},
      '{3, smm_pkg::CMD_DRAIN, 4'd0,  4'd0,  16'sd0,  1, smm_pkg::ST_DIM},
      '{4, smm_pkg::CMD_LOAD,  4'd0,  4'd0,  16'sd1,  1, smm_pkg::ST_DIM}
   };

   logic [smm_pkg::DIM_BITS-1:0] directed_dims [5][4] = '{
      '{5'd16, 5'd16, 5'd16, 5'd16},
      '{5'd4,  5'd6,  5'd6,  5'd5},
      '{5'd4,  5'd6,  5'd3,  5'd5},
      '{5'd0,  5'd16, 5'd16, 5'd16},
      '{5'd31, 5'd17, 5'd17, 5'd31}
   };

   initial begin
      int phase;
      int pick;
      logic [smm_pkg::CMD_BITS-1:0] cmd;
      logic [smm_pkg::IDX_BITS-1:0] row, col;
      logic [smm_pkg::DIM_BITS-1:0] ar, ac, bc;
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = smm_pkg::CMD_CLEAR;
      req.row_index = '0;
      req.col_index = '0;
      req.entry_value = '0;
      rsp.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = smm_pkg::REG_A_ROWS;
      csr_write_data = '0;
      foreach (dim_reg[i]) dim_reg[i] = 5'd16;
      foreach (row_count[i]) row_count[i] = '0;
      foreach (accumulator[i]) accumulator[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle = 32;
      recv_idle = 49;

      phase = -1;
      foreach (directed[i]) begin
         if (directed[i].phase != phase) begin
            phase = directed[i].phase;
            set_dims(directed_dims[phase][0], directed_dims[phase][1],
                     directed_dims[phase][2], directed_dims[phase][3]);
         end
         send_request(directed[i].cmd, directed[i].row, directed[i].col, directed[i].value,
                      directed[i].fixed, directed[i].status);
      end

      // Fill one B row past capacity, then accumulate until the cell wraps.
      set_dims(5'd16, 5'd16, 5'd16, 5'd16);
      send_request(smm_pkg::CMD_CLEAR, 4'd0, 4'd0, 16'sd0);
      repeat (17) send_request(smm_pkg::CMD_LOAD, 4'd1, 4'd3, -16'sd32768);
      repeat (40) send_request(smm_pkg::CMD_APPLY, 4'd2, 4'd1, -16'sd32768);
      send_request(smm_pkg::CMD_DRAIN, 4'd2, 4'd0, 16'sd0);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_dims(5'd16, 5'd16, 5'd16, 5'd16);
            1: set_dims(5'd1, 5'd1, 5'd1, 5'd1);
            2: set_dims(5'd16, 5'd1, 5'd1, 5'd16);
            3: set_dims(5'd1, 5'd16, 5'd16, 5'd1);
            default: begin
               ar = smm_pkg::DIM_BITS'($urandom_range(1, 16));
               ac = smm_pkg::DIM_BITS'($urandom_range(1, 16));
               bc = smm_pkg::DIM_BITS'($urandom_range(1, 16));
               set_dims(ar, ac, ac, bc);
            end
         endcase
         if (p == 2) begin
            send_idle = 49;
            recv_idle = 32;
         end else if (p == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         send_request(smm_pkg::CMD_CLEAR, 4'd0, 4'd0, 16'sd0);
         for (int n = 0; n < 31; n++) begin
            if (p == 5 && n == 5) hold_go = 1;
            pick = $urandom_range(99);
            cmd = (pick < 3) ? smm_pkg::CMD_CLEAR : (pick < 45) ? smm_pkg::CMD_LOAD :
                  (pick < 85) ? smm_pkg::CMD_APPLY : smm_pkg::CMD_DRAIN;
            if (cmd == smm_pkg::CMD_LOAD) begin
               row = smm_pkg::IDX_BITS'($urandom_range(int'(dim_reg[smm_pkg::REG_B_ROWS]) - 1));
               col = smm_pkg::IDX_BITS'($urandom_range(int'(dim_reg[smm_pkg::REG_B_COLS]) - 1));
            end else begin
               row = smm_pkg::IDX_BITS'($urandom_range(int'(dim_reg[smm_pkg::REG_A_ROWS]) - 1));
               col = smm_pkg::IDX_BITS'($urandom_range(int'(dim_reg[smm_pkg::REG_A_COLS]) - 1));
            end
            if ($urandom_range(9) == 0) begin
               row = smm_pkg::IDX_BITS'($urandom);
               col = smm_pkg::IDX_BITS'($urandom);
            end
            send_request(cmd, row, col, smm_pkg::IN_VALUE_BITS'($urandom));
         end
      end

      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
